### src/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection core.
// Used by the divider cell, the divider chain and the top level.
package rbsi_pkg;

   localparam int HALF_BITS = 31;
   localparam int DIR_BITS  = 16;
   localparam int FRAC_DIR  = 14;
   // numerator: (+-h - o) << 14, h 31 bits, o up to 32 bits
   localparam int NUM_BITS  = 34 + FRAC_DIR;
   localparam int QUO_BITS  = NUM_BITS;
   localparam int DEN_BITS  = DIR_BITS - 1;
   localparam int NDIV      = 6;

   // one slot of the divider chain: magnitudes, partial remainders, signs
   typedef struct packed {
      logic [NDIV-1:0][NUM_BITS-1:0] quo;
      logic [NDIV-1:0][DEN_BITS:0]   rem;
      logic [NDIV-1:0][DEN_BITS-1:0] den;
      logic [NDIV-1:0]               neg;
      logic [2:0]                    dzero;
      logic                          missed;
   } slot_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } ctl_type;

endpackage

### src/rbsi_div_cell.sv
// One restoring division step for all six quotients of a ray.
// Depends on rbsi_pkg; instanced in a row by rbsi_div_chain.
module rbsi_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  rbsi_pkg::ctl_type   ctl,
   input  rbsi_pkg::slot_type  slot_in,
   output rbsi_pkg::slot_type  slot_out,
   output logic                valid_out
);

   rbsi_pkg::slot_type slot_in_c;
   rbsi_pkg::slot_type slot_ff;
   logic               valid_ff;
   logic [rbsi_pkg::DEN_BITS+1:0] trial;

   always_comb begin
      slot_in_c = slot_in;
      trial = '0;
      for (int i = 0; i < rbsi_pkg::NDIV; i++) begin
         trial = {slot_in.rem[i], slot_in.quo[i][rbsi_pkg::NUM_BITS-1]};
         if (trial >= {1'b0, 1'b0, slot_in.den[i]}) begin
            trial = trial - {2'b00, slot_in.den[i]};
            slot_in_c.quo[i] = {slot_in.quo[i][rbsi_pkg::NUM_BITS-2:0], 1'b1};
         end else begin
            slot_in_c.quo[i] = {slot_in.quo[i][rbsi_pkg::NUM_BITS-2:0], 1'b0};
         end
         slot_in_c.rem[i] = trial[rbsi_pkg::DEN_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         slot_ff <= slot_in_c;
      end
   end

   assign slot_out  = slot_ff;
   assign valid_out = valid_ff;

endmodule

### src/rbsi_div_chain.sv
// Row of division cells, one quotient bit per cell per cycle while advance is high.
// Depends on rbsi_pkg and rbsi_div_cell.
module rbsi_div_chain (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                valid_in,
   input  rbsi_pkg::slot_type  slot_in,
   output rbsi_pkg::slot_type  slot_out,
   output logic                valid_out
);

   rbsi_pkg::slot_type slots [rbsi_pkg::QUO_BITS+1];
   logic               valids [rbsi_pkg::QUO_BITS+1];

   assign slots[0]  = slot_in;
   assign valids[0] = valid_in;

   for (genvar k = 0; k < rbsi_pkg::QUO_BITS; k++) begin : g_cell
      rbsi_pkg::ctl_type ctl;
      assign ctl.valid   = valids[k];
      assign ctl.advance = advance;
      rbsi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .slot_in   (slots[k]),
         .slot_out  (slots[k+1]),
         .valid_out (valids[k+1])
      );
   end

   assign slot_out  = slots[rbsi_pkg::QUO_BITS];
   assign valid_out = valids[rbsi_pkg::QUO_BITS];

endmodule

### src/ray_box_slab_intersection_core.sv
// Top level of the ray/box slab intersection core.
// Depends on rbsi_pkg and rbsi_div_chain.
//
// Usage:
//   Requests arrive on req_* (origin xyz, direction xyz) and results leave
//   on rsp_* (hit, distance). Box half extents are written over csr_* at
//   byte addresses 0, 4 and 8 while the core is idle; reset sets each to 1.0.
//   A request enters per cycle while req_tready is high. Stages: one prepare
//   stage, 48 division cells (one quotient bit each, six quotients side by
//   side) and two stages for the min/max reduction and the output register.
//   Throughput is one request per cycle, set by the cell row, unless stalled.
//   The pipeline advances whenever the output register is empty or taken;
//   a stall on rsp_tready freezes every stage and drops req_tready.
//   Reset empties the pipeline and restores the half extents.
module ray_box_slab_intersection_core #(
   parameter int COORD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x[31:0], origin_y[63:32], origin_z[95:64],
   // dir_x[111:96], dir_y[127:112], dir_z[143:128]
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance[30:0]
   output logic [31:0]  rsp_tdata,
   // hit
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int OB = (COORD_BITS > 32) ? 32 : COORD_BITS;
   localparam int NB = rbsi_pkg::NUM_BITS;
   localparam logic [1:0] REG_X = 2'd0;
   localparam logic [1:0] REG_Y = 2'd1;
   localparam logic [1:0] REG_Z = 2'd2;

   logic [rbsi_pkg::HALF_BITS-1:0] half_ff [3];
   logic advance;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) half_ff[a] <= 31'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            REG_X:   half_ff[0] <= csr_pwdata[30:0];
            REG_Y:   half_ff[1] <= csr_pwdata[30:0];
            REG_Z:   half_ff[2] <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_X:   csr_prdata = {1'b0, half_ff[0]};
         REG_Y:   csr_prdata = {1'b0, half_ff[1]};
         REG_Z:   csr_prdata = {1'b0, half_ff[2]};
         default: csr_prdata = '0;
      endcase
   end

   // prepare stage: numerators and divisor magnitudes
   rbsi_pkg::slot_type prep_in, prep_ff;
   logic               prep_vld_ff;
   logic signed [33:0] org [3];
   logic signed [15:0] dir [3];
   logic signed [33:0] num [6];
   logic [33:0]        mag;

   always_comb begin
      prep_in = '0;
      mag = '0;
      for (int a = 0; a < 3; a++) begin
         org[a] = 34'(signed'(req_tdata[a*32 +: OB]));
         dir[a] = signed'(req_tdata[96 + a*16 +: 16]);
         num[2*a]   = -$signed({3'b000, half_ff[a]}) - org[a];
         num[2*a+1] =  $signed({3'b000, half_ff[a]}) - org[a];
         prep_in.dzero[a] = (dir[a] == 16'sd0);
         if (prep_in.dzero[a] && (num[2*a] > 34'sd0 || num[2*a+1] < 34'sd0))
            prep_in.missed = 1'b1;
         for (int s = 0; s < 2; s++) begin
            mag = num[2*a+s][33] ? 34'(-num[2*a+s]) : 34'(num[2*a+s]);
            prep_in.quo[2*a+s] = {mag, {rbsi_pkg::FRAC_DIR{1'b0}}};
            prep_in.den[2*a+s] = dir[a][15] ? 15'(-dir[a]) : dir[a][14:0];
            prep_in.neg[2*a+s] = num[2*a+s][33] ^ dir[a][15];
         end
      end
      // dir of -32768: magnitude 2^15 does not fit in den; see big_ff
   end

   // divisor of 32768 needs 16 bits; big_ff flags it for a pre-shift at the chain input
   logic [2:0] big_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (advance) begin
         prep_vld_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
         for (int a = 0; a < 3; a++) big_ff[a] <= (dir[a] == -16'sd32768);
      end
   end

   rbsi_pkg::slot_type chain_in, div_out;
   logic               div_vld;
   always_comb begin
      chain_in = prep_ff;
      for (int i = 0; i < 6; i++) begin
         if (big_ff[i >> 1]) begin
            // divide by 2^15: pre-shift numerator, divisor 1
            chain_in.quo[i] = NB'(prep_ff.quo[i] >> 15);
            chain_in.den[i] = 15'd1;
         end
      end
   end

   rbsi_div_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (prep_vld_ff),
      .slot_in   (chain_in),
      .slot_out  (div_out),
      .valid_out (div_vld)
   );

   // reduction stage
   logic signed [NB:0] t [6];
   logic signed [NB:0] lo, hi, alo, ahi;
   logic               limited;
   logic signed [NB:0] lo_ff, hi_ff;
   logic               ok_in, ok_ff, red_vld_ff;

   always_comb begin
      lo = '0;
      hi = '0;
      alo = '0;
      ahi = '0;
      limited = 1'b0;
      for (int i = 0; i < 6; i++)
         t[i] = div_out.neg[i] ? -$signed({1'b0, div_out.quo[i]})
                               :  $signed({1'b0, div_out.quo[i]});
      for (int a = 0; a < 3; a++) begin
         if (!div_out.dzero[a]) begin
            alo = (t[2*a] < t[2*a+1]) ? t[2*a] : t[2*a+1];
            ahi = (t[2*a] < t[2*a+1]) ? t[2*a+1] : t[2*a];
            if (!limited) begin
               lo = alo;
               hi = ahi;
            end else begin
               if (alo > lo) lo = alo;
               if (ahi < hi) hi = ahi;
            end
            limited = 1'b1;
         end
      end
      ok_in = limited && !div_out.missed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_vld_ff <= 1'b0;
      end else if (advance) begin
         red_vld_ff <= div_vld;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff <= lo;
         hi_ff <= hi;
         ok_ff <= ok_in;
      end
   end

   // output register
   logic               hit_in;
   logic signed [NB:0] dsel;
   logic [30:0]        dist_in;
   logic               out_vld_ff, hit_ff;
   logic [30:0]        dist_ff;

   always_comb begin
      hit_in = ok_ff && !hi_ff[NB] && !(lo_ff > hi_ff);
      dsel = (lo_ff > 0) ? lo_ff : hi_ff;
      if (!hit_in) dist_in = '0;
      else if (dsel > $signed((NB+1)'(32'h7FFF_FFFF))) dist_in = 31'h7FFF_FFFF;
      else dist_in = dsel[30:0];
   end

   assign advance = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= red_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, dist_ff};
   assign rsp_tuser  = hit_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("miss with nonzero distance");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(red_vld_ff) && $stable(prep_vld_ff))
      else $error("pipeline moved during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");

endmodule
